### design/dqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query encoder package
// Shared types and constants of the DNS query message builder.
// ----------------------------------------------------------------------------
package dqe_pkg;

  // Bytes packed into one result, first byte in the lowest bits.
  localparam int unsigned BYTES_PER_RESULT = 8;
  localparam logic [3:0]  RESULT_FULL      = 4'(BYTES_PER_RESULT);

  // Character that separates labels.
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Fixed message bytes.
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [7:0] FLAG_RD     = 8'h01;
  localparam logic [7:0] QDCOUNT_LO  = 8'h01;
  localparam logic [7:0] CLASS_IN_LO = 8'h01;

  // Byte positions within the header and the trailer.
  localparam logic [3:0] HDR_ID_HI   = 4'd0;
  localparam logic [3:0] HDR_ID_LO   = 4'd1;
  localparam logic [3:0] HDR_FLAGS   = 4'd2;
  localparam logic [3:0] HDR_QDCOUNT = 4'd5;
  localparam logic [3:0] HDR_LAST    = 4'd11;
  localparam logic [3:0] TAIL_TYPE_HI = 4'd1;
  localparam logic [3:0] TAIL_TYPE_LO = 4'd2;
  localparam logic [3:0] TAIL_LAST    = 4'd4;

  // One byte offered by the sequencer to the packer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;  // last byte of the request's output
    logic       eom;   // request closes a message
    logic       err;   // error result instead of a byte
  } push_t;

endpackage

### design/dqe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/dqe_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query encoder byte packer
// Gathers bytes into result words and holds the result output register.
// ----------------------------------------------------------------------------
module dqe_packer (
  input  logic               clk,
  input  logic               rst,
  input  dqe_pkg::push_t     push,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        data_bytes,
  output logic [3:0]         byte_count,
  output logic               status,
  output logic               end_of_message
);
  import dqe_pkg::*;

  logic [63:0] acc;
  logic [2:0]  cnt;
  logic [63:0] acc_ins;
  logic [3:0]  cnt_inc;
  logic        complete;
  logic        take;
  logic        load;

  assign take       = out_valid && !out_stall;
  assign push_ready = !out_valid || !out_stall;
  assign load       = push.valid && push_ready && (push.err || complete);

  always_comb begin
    acc_ins = acc;
    acc_ins[cnt*8 +: 8] = push.data;
    cnt_inc  = {1'b0, cnt} + 4'd1;
    complete = push.last || (cnt_inc == RESULT_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
      cnt       <= '0;
    end else begin
      // A new result replaces the one being taken in the same cycle.
      if (load) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (push.valid && push_ready) begin
        if (push.err) begin
          data_bytes     <= '0;
          byte_count     <= '0;
          status         <= 1'b1;
          end_of_message <= 1'b1;
        end else if (complete) begin
          data_bytes     <= acc_ins;
          byte_count     <= cnt_inc;
          status         <= 1'b0;
          end_of_message <= push.last && push.eom;
          acc            <= '0;
          cnt            <= '0;
        end else begin
          acc <= acc_ins;
          cnt <= cnt_inc[2:0];
        end
      end
    end
  end

endmodule

### design/dqe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query encoder sequencer
// Decodes each character, buffers labels and steps through message bytes.
// ----------------------------------------------------------------------------
module dqe_seq #(
  parameter int unsigned LABEL_LIMIT = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     name_char,
  input  logic           final_char,
  input  logic [15:0]    query_id,
  input  logic [15:0]    query_type,
  output logic           busy,
  input  logic           push_ready,
  output dqe_pkg::push_t push
);
  import dqe_pkg::*;

  localparam int unsigned LW = $clog2(LABEL_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_LABLEN,
    S_LABEL,
    S_TAIL,
    S_ERR
  } state_t;

  state_t        state;
  logic [3:0]    idx;
  logic [LW-1:0] lidx;
  logic [LW-1:0] emit_len;
  logic [LW-1:0] label_length;
  logic          inside_name;
  logic          skipping;
  logic          do_label;
  logic          do_tail;
  logic          do_err;
  logic [15:0]   qid;
  logic [15:0]   qtype;

  logic          accept;
  logic          is_dot;
  logic [LW-1:0] len_eff;
  logic [LW:0]   len_ext;
  logic          bad;
  logic          store;
  logic          emit_label;
  logic          adv;
  logic [LW-1:0] raddr;
  logic [7:0]    rdata;

  assign busy   = (state != S_IDLE);
  assign accept = in_valid && (state == S_IDLE);
  assign adv    = push.valid && push_ready;

  always_comb begin
    is_dot     = (name_char == DOT_CHAR);
    len_eff    = inside_name ? label_length : '0;
    len_ext    = {1'b0, len_eff} + 1'b1;
    bad        = is_dot ? (len_eff == '0) : (len_ext >= (LW+1)'(LABEL_LIMIT));
    store      = accept && !skipping && !is_dot && !bad;
    emit_label = !bad && (is_dot || final_char);
  end

  // Label bytes are read one ahead so that the data is ready when needed.
  always_comb begin
    if (state == S_LABEL) begin
      raddr = adv ? lidx + 1'b1 : lidx;
    end else begin
      raddr = '0;
    end
  end

  dqe_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_LIMIT)
  ) u_label_ram (
    .clk   (clk),
    .we    (store),
    .waddr (len_eff),
    .wdata (name_char),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    push       = '0;
    push.valid = busy;
    push.eom   = (state == S_TAIL);
    unique case (state)
      S_HDR: begin
        unique case (idx)
          HDR_ID_HI:   push.data = qid[15:8];
          HDR_ID_LO:   push.data = qid[7:0];
          HDR_FLAGS:   push.data = FLAG_RD;
          HDR_QDCOUNT: push.data = QDCOUNT_LO;
          default:     push.data = ZERO_BYTE;
        endcase
        push.last = (idx == HDR_LAST) && !do_label;
      end
      S_LABLEN: begin
        push.data = 8'(emit_len);
      end
      S_LABEL: begin
        push.data = rdata;
        push.last = (lidx == emit_len - 1'b1) && !do_tail;
      end
      S_TAIL: begin
        unique case (idx)
          TAIL_TYPE_HI: push.data = qtype[15:8];
          TAIL_TYPE_LO: push.data = qtype[7:0];
          TAIL_LAST:    push.data = CLASS_IN_LO;
          default:      push.data = ZERO_BYTE;
        endcase
        push.last = (idx == TAIL_LAST);
      end
      S_ERR: begin
        push.err = 1'b1;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      label_length <= '0;
      inside_name  <= 1'b0;
      skipping     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (skipping) begin
              if (final_char) begin
                skipping     <= 1'b0;
                inside_name  <= 1'b0;
                label_length <= '0;
              end
            end else begin
              qid      <= query_id;
              qtype    <= query_type;
              idx      <= '0;
              lidx     <= '0;
              emit_len <= is_dot ? len_eff : len_ext[LW-1:0];
              do_label <= emit_label;
              do_tail  <= final_char && !bad;
              do_err   <= bad;
              if (bad) begin
                label_length <= '0;
                inside_name  <= 1'b0;
                skipping     <= !final_char;
              end else if (final_char || is_dot) begin
                label_length <= '0;
                inside_name  <= !final_char;
              end else begin
                label_length <= len_ext[LW-1:0];
                inside_name  <= 1'b1;
              end
              if (!inside_name) begin
                state <= S_HDR;
              end else if (emit_label) begin
                state <= S_LABLEN;
              end else if (bad) begin
                state <= S_ERR;
              end
            end
          end
        end
        S_HDR: begin
          if (adv) begin
            if (idx == HDR_LAST) begin
              idx <= '0;
              if (do_label) begin
                state <= S_LABLEN;
              end else if (do_err) begin
                state <= S_ERR;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        S_LABLEN: begin
          if (adv) begin
            state <= S_LABEL;
          end
        end
        S_LABEL: begin
          if (adv) begin
            lidx <= lidx + 1'b1;
            if (lidx == emit_len - 1'b1) begin
              state <= do_tail ? S_TAIL : S_IDLE;
            end
          end
        end
        S_TAIL: begin
          if (adv) begin
            idx <= idx + 4'd1;
            if (idx == TAIL_LAST) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/dns_query_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query encoder
// Builds a DNS query message from a domain name given one character a request.
// ----------------------------------------------------------------------------
// The block takes one character of a domain name per request and produces the
// DNS query message as results of up to eight bytes, first byte in the lowest
// bits. A single sequencer steps through the message one byte per clock unless
// the output is held, and a packer gathers the bytes into result words, so the
// work of a request is set by the bytes it produces: a plain label character
// produces none, the first character of a name adds the twelve header bytes,
// a dot or final character adds the length byte plus the label bytes, a final
// character adds five more for the closing zero, the type and the class, and
// an error adds an error result. While the sequencer is working, in_stall is
// high; a held output stalls the sequencer rather than losing bytes. Labels
// are held in a RAM of LABEL_LIMIT bytes, which needs no clearing after reset.
// ----------------------------------------------------------------------------
module dns_query_encoder #(
  parameter int unsigned LABEL_LIMIT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  name_char,
  input  logic        final_char,
  input  logic [15:0] query_id,
  input  logic [15:0] query_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_bytes,
  output logic [3:0]  byte_count,
  output logic        status,
  output logic        end_of_message
);
  import dqe_pkg::*;

  push_t push;
  logic  push_ready;
  logic  busy;

  // The sequencer refuses new requests until every byte of the current one
  // has been handed to the packer.
  assign in_stall = busy;

  dqe_seq #(
    .LABEL_LIMIT (LABEL_LIMIT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .name_char  (name_char),
    .final_char (final_char),
    .query_id   (query_id),
    .query_type (query_type),
    .busy       (busy),
    .push_ready (push_ready),
    .push       (push)
  );

  // The packer owns the result register, so a finished result waits there
  // while the sequencer moves on to the next request.
  dqe_packer u_packer (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .push_ready     (push_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_bytes     (data_bytes),
    .byte_count     (byte_count),
    .status         (status),
    .end_of_message (end_of_message)
  );

`ifndef ASSERT_OFF
  // An error result carries no bytes and closes the message.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (byte_count == 4'd0) && end_of_message && (data_bytes == 64'd0))
    else $error("error result malformed");

  // A normal result carries between one and a full word of bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (byte_count != 4'd0) && (byte_count <= RESULT_FULL))
    else $error("result byte count out of range");

  // A new result can only appear when the previous one was taken or absent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_count) && $stable(status))
    else $error("held result changed");
`endif

endmodule
